@@ rtl/core/ddo_pkg.sv @@
// Shared types, constants and arithmetic helpers for the odometry block.
package ddo_pkg;

	localparam logic [15:0] QUARTER_TURN  = 16'd16384;
	localparam logic [15:0] THREE_QUARTER = 16'd49152;
	localparam logic signed [51:0] CORDIC_GAIN = 52'sd652032874;

	localparam logic [1:0] REG_CIRC  = 2'd0;
	localparam logic [1:0] REG_PPR   = 2'd1;
	localparam logic [1:0] REG_GEAR  = 2'd2;
	localparam logic [1:0] REG_WIDTH = 2'd3;

	typedef enum logic [4:0] {
		OP_NOP, OP_LOAD, OP_MULT, OP_DIV, OP_GEAR, OP_DIST, OP_SPLIT,
		OP_CINIT, OP_CSTEP, OP_CFIN, OP_SX1, OP_SX2, OP_SY1, OP_SY2,
		OP_OFFS, OP_PX1, OP_PX2, OP_PXF, OP_PY1, OP_PY2, OP_PYF,
		OP_HEAD, OP_OUT
	} op_t;

	typedef enum logic [1:0] {J_STR, J_ATAN, J_HROT, J_ANG} job_t;

	typedef struct packed {
		op_t        op;
		logic       sel;
		job_t       job;
		logic [4:0] idx;
	} cmd_t;

	typedef struct packed {
		logic same_sign;
		logic dr_nz;
		logic dl_nz;
	} stat_t;

	// Arctangent of 2^-i in units of 2^-32 turn.
	function automatic logic [31:0] atan_lut(input logic [4:0] i);
		logic [31:0] r;
		case (i)
			5'd0:  r = 32'h20000000;
			5'd1:  r = 32'h12E4051E;
			5'd2:  r = 32'h09FB385B;
			5'd3:  r = 32'h051111D4;
			5'd4:  r = 32'h028B0D43;
			5'd5:  r = 32'h0145D7E1;
			5'd6:  r = 32'h00A2F61E;
			5'd7:  r = 32'h00517C55;
			5'd8:  r = 32'h0028BE53;
			5'd9:  r = 32'h00145F2F;
			5'd10: r = 32'h000A2F98;
			5'd11: r = 32'h000517CC;
			5'd12: r = 32'h00028BE6;
			5'd13: r = 32'h000145F3;
			5'd14: r = 32'h0000A2FA;
			5'd15: r = 32'h0000517D;
			5'd16: r = 32'h000028BE;
			5'd17: r = 32'h0000145F;
			5'd18: r = 32'h00000A30;
			5'd19: r = 32'h00000518;
			5'd20: r = 32'h0000028C;
			5'd21: r = 32'h00000146;
			5'd22: r = 32'h000000A3;
			5'd23: r = 32'h00000051;
			default: r = 32'h00000000;
		endcase
		return r;
	endfunction

	function automatic logic signed [15:0] sat16(input logic signed [49:0] v);
		logic signed [15:0] r;
		if (v > 50'sd32767)
			r = 16'sh7FFF;
		else if (v < -50'sd32768)
			r = 16'sh8000;
		else
			r = v[15:0];
		return r;
	endfunction

	// Round a Q2.30 value to Q1.15, limited to +-32767.
	function automatic logic signed [15:0] round_q15(input logic signed [51:0] v);
		logic signed [51:0] r;
		logic signed [15:0] o;
		r = v + 52'sd16384;
		r = r >>> 15;
		if (r > 52'sd32767)
			o = 16'sd32767;
		else if (r < -52'sd32767)
			o = -16'sd32767;
		else
			o = r[15:0];
		return o;
	endfunction

endpackage

@@ rtl/core/ddo_dp.sv @@
// Datapath: configuration, pose registers, divider, CORDIC and multiplier.
module ddo_dp import ddo_pkg::*; #(
	parameter int START_X = 90,
	parameter int START_Y = 90
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               wr_en,
	input  logic [1:0]         wr_index,
	input  logic [15:0]        wr_data,
	input  logic signed [15:0] right_ticks,
	input  logic signed [15:0] left_ticks,
	input  cmd_t               cmd,
	output stat_t              stat,
	output logic signed [15:0] pos_x,
	output logic signed [15:0] pos_y,
	output logic [15:0]        heading
);

	localparam logic signed [15:0] X_RST = 16'(START_X);
	localparam logic signed [15:0] Y_RST = 16'(START_Y);

	logic [15:0] circ_q, ppr_q, hd_q;
	logic [7:0]  gear_q;
	logic [9:0]  width_q;
	logic signed [15:0] x_q, y_q;

	logic signed [15:0] rt_q, lt_q, c_q, s_q, px_q, py_q;
	logic [15:0] ang_q, ph_q;
	logic [31:0] num_q;
	logic [15:0] rem_q, dvs_q;
	logic        neg_q, sc_neg_q;
	logic signed [32:0] dr_q, dl_q, m_q;
	logic signed [51:0] cx_q, cy_q;
	logic signed [33:0] cz_q;
	logic signed [26:0] ox_q, oy_q;
	logic signed [49:0] prod_q, acc_q;

	logic signed [15:0] tk, ma, crn, srn;
	logic signed [32:0] tprod, tmag, dq, dval, mval, ad, mb;
	logic [16:0] dsh, dsub;
	logic        dge, plus_dir;
	logic [15:0] ang_in;
	logic signed [33:0] za, zi, at, zr;
	logic        qneg;
	logic signed [51:0] xs, ys;
	logic signed [48:0] mp;
	logic signed [26:0] nox, noy, oxp, oyp;
	logic signed [10:0] ow;
	logic signed [49:0] sq, sxn, syn, rr, wx, nx, tr;
	logic signed [15:0] base;
	logic signed [26:0] offs;

	always_comb begin
		tk    = cmd.sel ? lt_q : rt_q;
		tprod = tk * $signed({1'b0, circ_q});
		tmag  = tprod[32] ? -tprod : tprod;

		dsh  = {rem_q, num_q[31]};
		dge  = dsh >= {1'b0, dvs_q};
		dsub = dsh - {1'b0, dvs_q};

		dq   = $signed({1'b0, num_q});
		dval = neg_q ? -dq : dq;

		if (dr_q > 0)
			mval = (dr_q < dl_q) ? dr_q : dl_q;
		else
			mval = (dr_q > dl_q) ? dr_q : dl_q;

		ad = cmd.sel ? -dl_q : dr_q;

		case (cmd.job)
			J_STR:   ang_in = hd_q;
			J_HROT:  ang_in = hd_q + (cmd.sel ? QUARTER_TURN : THREE_QUARTER);
			J_ANG:   ang_in = ang_q;
			default: ang_in = hd_q;
		endcase
		za = $signed({2'b00, ang_in, 16'h0000});
		qneg = 1'b0;
		if (ang_in >= QUARTER_TURN && ang_in < THREE_QUARTER) begin
			zi   = za - 34'sd2147483648;
			qneg = 1'b1;
		end else if (ang_in >= THREE_QUARTER) begin
			zi = za - 34'sd4294967296;
		end else begin
			zi = za;
		end

		xs = cx_q >>> cmd.idx;
		ys = cy_q >>> cmd.idx;
		at = $signed({2'b00, atan_lut(cmd.idx)});
		// Vectoring drives y toward zero, rotation drives z toward zero.
		plus_dir = (cmd.job == J_ATAN) ? (cy_q > 0) : (cz_q < 0);
		zr = cz_q + 34'sd32768;
		crn = round_q15(cx_q);
		srn = round_q15(cy_q);

		nox = -ox_q;
		noy = -oy_q;
		case (cmd.op)
			OP_SX1:  begin ma = c_q; mb = m_q; end
			OP_SY1:  begin ma = s_q; mb = m_q; end
			OP_PX1:  begin ma = c_q; mb = 33'(nox); end
			OP_PX2:  begin ma = s_q; mb = 33'(noy); end
			OP_PY1:  begin ma = s_q; mb = 33'(nox); end
			OP_PY2:  begin ma = c_q; mb = 33'(noy); end
			default: begin ma = c_q; mb = m_q; end
		endcase
		mp = ma * mb;

		ow  = $signed({1'b0, width_q});
		oxp = c_q * ow;
		oyp = s_q * ow;

		// Truncating divide by 2^15.
		if (prod_q < 0)
			sq = (prod_q + 50'sd32767) >>> 15;
		else
			sq = prod_q >>> 15;
		sxn = 50'(x_q) + sq;
		syn = 50'(y_q) - sq;

		rr   = acc_q + 50'sd16384;
		rr   = rr >>> 15;
		base = (cmd.op == OP_PXF) ? x_q : y_q;
		offs = (cmd.op == OP_PXF) ? ox_q : oy_q;
		wx   = (50'(base) <<< 16) + 50'(offs);
		nx   = rr + wx;
		if (nx < 0)
			tr = (nx + 50'sd65535) >>> 16;
		else
			tr = nx >>> 16;
	end

	assign stat.same_sign = (dr_q > 0 && dl_q > 0) || (dr_q < 0 && dl_q < 0);
	assign stat.dr_nz     = dr_q != 0;
	assign stat.dl_nz     = dl_q != 0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			circ_q  <= 16'd1;
			ppr_q   <= 16'd1;
			gear_q  <= 8'd1;
			width_q <= 10'd100;
			x_q     <= X_RST;
			y_q     <= Y_RST;
			hd_q    <= 16'h8000;
		end else begin
			if (wr_en) begin
				case (wr_index)
					REG_CIRC:  circ_q  <= wr_data;
					REG_PPR:   ppr_q   <= wr_data;
					REG_GEAR:  gear_q  <= wr_data[7:0];
					REG_WIDTH: width_q <= wr_data[9:0];
					default: ;
				endcase
			end
			case (cmd.op)
				OP_SX2:  x_q  <= sat16(sxn);
				OP_SY2:  y_q  <= sat16(syn);
				OP_PXF:  x_q  <= sat16(tr);
				OP_PYF:  y_q  <= sat16(tr);
				OP_HEAD: hd_q <= hd_q + ang_q;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				rt_q <= right_ticks;
				lt_q <= left_ticks;
			end
			OP_MULT: begin
				num_q <= tmag[31:0];
				neg_q <= tprod[32];
				rem_q <= '0;
				dvs_q <= (ppr_q == 16'd0) ? 16'd1 : ppr_q;
			end
			OP_DIV: begin
				rem_q <= dge ? dsub[15:0] : dsh[15:0];
				num_q <= {num_q[30:0], dge};
			end
			OP_GEAR: begin
				rem_q <= '0;
				dvs_q <= (gear_q == 8'd0) ? 16'd1 : {8'd0, gear_q};
			end
			OP_DIST: begin
				if (cmd.sel)
					dl_q <= dval;
				else
					dr_q <= dval;
			end
			OP_SPLIT: begin
				m_q  <= mval;
				dr_q <= dr_q - mval;
				dl_q <= dl_q - mval;
			end
			OP_CINIT: begin
				if (cmd.job == J_ATAN) begin
					cx_q <= $signed({26'd0, width_q, 16'h0000});
					cy_q <= $signed({{19{ad[32]}}, ad}) <<< 16;
					cz_q <= '0;
				end else begin
					cx_q     <= CORDIC_GAIN;
					cy_q     <= '0;
					cz_q     <= zi;
					sc_neg_q <= qneg;
				end
			end
			OP_CSTEP: begin
				if (plus_dir) begin
					cx_q <= cx_q + ys;
					cy_q <= cy_q - xs;
					cz_q <= cz_q + at;
				end else begin
					cx_q <= cx_q - ys;
					cy_q <= cy_q + xs;
					cz_q <= cz_q - at;
				end
			end
			OP_CFIN: begin
				if (cmd.job == J_ATAN) begin
					ang_q <= zr[31:16];
				end else begin
					c_q <= sc_neg_q ? -crn : crn;
					s_q <= sc_neg_q ? -srn : srn;
				end
			end
			OP_SX1, OP_SY1, OP_PX1, OP_PY1: prod_q <= 50'(mp);
			OP_PX2:  acc_q <= prod_q - 50'(mp);
			OP_PY2:  acc_q <= prod_q + 50'(mp);
			OP_OFFS: begin
				ox_q <= oxp;
				oy_q <= -oyp;
			end
			OP_OUT: begin
				px_q <= x_q;
				py_q <= y_q;
				ph_q <= hd_q;
			end
			default: ;
		endcase
	end

	assign pos_x   = px_q;
	assign pos_y   = py_q;
	assign heading = ph_q;

endmodule

@@ rtl/core/ddo_ctrl.sv @@
// Controller: sequences the datapath through conversion, straight move and pivots.
module ddo_ctrl import ddo_pkg::*; #(
	parameter int CORDIC_STEPS = 16
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_stall,
	output logic  out_valid,
	input  logic  out_stall,
	input  stat_t stat,
	output cmd_t  cmd
);

	localparam logic [4:0] LAST_STEP = 5'(CORDIC_STEPS - 1);
	localparam logic [4:0] DIV_LAST  = 5'd31;

	typedef enum logic [23:0] {
		ST_IDLE  = 24'h000001, ST_MUL   = 24'h000002, ST_DIVA  = 24'h000004,
		ST_GEAR  = 24'h000008, ST_DIVB  = 24'h000010, ST_DIST  = 24'h000020,
		ST_SPLIT = 24'h000040, ST_CINIT = 24'h000080, ST_CSTEP = 24'h000100,
		ST_CFIN  = 24'h000200, ST_SX1   = 24'h000400, ST_SX2   = 24'h000800,
		ST_SY1   = 24'h001000, ST_SY2   = 24'h002000, ST_PCHK  = 24'h004000,
		ST_OFFS  = 24'h008000, ST_PX1   = 24'h010000, ST_PX2   = 24'h020000,
		ST_PXF   = 24'h040000, ST_PY1   = 24'h080000, ST_PY2   = 24'h100000,
		ST_PYF   = 24'h200000, ST_HEAD  = 24'h400000, ST_OUT   = 24'h800000
	} state_t;

	state_t     state_q, state_d;
	logic       sel_q, sel_d, ov_q, ov_d;
	job_t       job_q, job_d;
	logic [4:0] cnt_q, cnt_d;

	always_comb begin
		state_d = state_q;
		sel_d   = sel_q;
		job_d   = job_q;
		cnt_d   = cnt_q;
		ov_d    = out_stall ? ov_q : 1'b0;
		cmd.op  = OP_NOP;
		cmd.sel = sel_q;
		cmd.job = job_q;
		cmd.idx = cnt_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.op  = OP_LOAD;
					sel_d   = 1'b0;
					state_d = ST_MUL;
				end
			end
			ST_MUL: begin
				cmd.op  = OP_MULT;
				cnt_d   = '0;
				state_d = ST_DIVA;
			end
			ST_DIVA: begin
				cmd.op = OP_DIV;
				cnt_d  = cnt_q + 5'd1;
				if (cnt_q == DIV_LAST)
					state_d = ST_GEAR;
			end
			ST_GEAR: begin
				cmd.op  = OP_GEAR;
				state_d = ST_DIVB;
			end
			ST_DIVB: begin
				cmd.op = OP_DIV;
				cnt_d  = cnt_q + 5'd1;
				if (cnt_q == DIV_LAST)
					state_d = ST_DIST;
			end
			ST_DIST: begin
				cmd.op = OP_DIST;
				if (!sel_q) begin
					sel_d   = 1'b1;
					state_d = ST_MUL;
				end else begin
					state_d = ST_SPLIT;
				end
			end
			ST_SPLIT: begin
				if (stat.same_sign) begin
					cmd.op  = OP_SPLIT;
					job_d   = J_STR;
					state_d = ST_CINIT;
				end else begin
					sel_d   = 1'b0;
					state_d = ST_PCHK;
				end
			end
			ST_CINIT: begin
				cmd.op  = OP_CINIT;
				cnt_d   = '0;
				state_d = ST_CSTEP;
			end
			ST_CSTEP: begin
				cmd.op = OP_CSTEP;
				if (cnt_q == LAST_STEP) begin
					cnt_d   = '0;
					state_d = ST_CFIN;
				end else begin
					cnt_d = cnt_q + 5'd1;
				end
			end
			ST_CFIN: begin
				cmd.op = OP_CFIN;
				case (job_q)
					J_STR:  state_d = ST_SX1;
					J_ATAN: begin
						job_d   = J_HROT;
						state_d = ST_CINIT;
					end
					J_HROT: state_d = ST_OFFS;
					default: state_d = ST_PX1;
				endcase
			end
			ST_SX1: begin cmd.op = OP_SX1; state_d = ST_SX2; end
			ST_SX2: begin cmd.op = OP_SX2; state_d = ST_SY1; end
			ST_SY1: begin cmd.op = OP_SY1; state_d = ST_SY2; end
			ST_SY2: begin
				cmd.op  = OP_SY2;
				sel_d   = 1'b0;
				state_d = ST_PCHK;
			end
			ST_PCHK: begin
				// The right wheel pivots first, then the left one.
				if (sel_q ? stat.dl_nz : stat.dr_nz) begin
					job_d   = J_ATAN;
					state_d = ST_CINIT;
				end else if (!sel_q) begin
					sel_d = 1'b1;
				end else begin
					state_d = ST_OUT;
				end
			end
			ST_OFFS: begin
				cmd.op  = OP_OFFS;
				job_d   = J_ANG;
				state_d = ST_CINIT;
			end
			ST_PX1: begin cmd.op = OP_PX1; state_d = ST_PX2; end
			ST_PX2: begin cmd.op = OP_PX2; state_d = ST_PXF; end
			ST_PXF: begin cmd.op = OP_PXF; state_d = ST_PY1; end
			ST_PY1: begin cmd.op = OP_PY1; state_d = ST_PY2; end
			ST_PY2: begin cmd.op = OP_PY2; state_d = ST_PYF; end
			ST_PYF: begin cmd.op = OP_PYF; state_d = ST_HEAD; end
			ST_HEAD: begin
				cmd.op = OP_HEAD;
				if (!sel_q) begin
					sel_d   = 1'b1;
					state_d = ST_PCHK;
				end else begin
					state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				if (!ov_q || !out_stall) begin
					cmd.op  = OP_OUT;
					ov_d    = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			sel_q   <= 1'b0;
			job_q   <= J_STR;
			cnt_q   <= '0;
			ov_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			sel_q   <= sel_d;
			job_q   <= job_d;
			cnt_q   <= cnt_d;
			ov_q    <= ov_d;
		end
	end

	assign in_stall  = state_q != ST_IDLE;
	assign out_valid = ov_q;

endmodule

@@ rtl/core/differential_drive_odometry_top.sv @@
// Differential-drive odometry: one item of signed wheel tick counts in, the
// updated position and heading out. The two wheel conversions run two 32-step
// restoring divisions each on one shared divider, and the straight move and
// each pivot use one shared CORDIC unit of CORDIC_STEPS iterations, once for
// the straight move and three times per pivot. An item makes either at most
// two pivots, or a straight move and at most one pivot, so the longest case is
// two pivots. A new item is taken while the previous result still waits in the
// output register; a result that is not taken holds the block before its next
// output.
module differential_drive_odometry_top import ddo_pkg::*; #(
	parameter int START_X      = 90,
	parameter int START_Y      = 90,
	parameter int CORDIC_STEPS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               wr_en,
	input  logic [1:0]         wr_index,
	input  logic [15:0]        wr_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [15:0] right_ticks,
	input  logic signed [15:0] left_ticks,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [15:0] pos_x,
	output logic signed [15:0] pos_y,
	output logic [15:0]        heading
);

	cmd_t  cmd;
	stat_t stat;

	ddo_ctrl #(
		.CORDIC_STEPS(CORDIC_STEPS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	ddo_dp #(
		.START_X(START_X),
		.START_Y(START_Y)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.wr_en       (wr_en),
		.wr_index    (wr_index),
		.wr_data     (wr_data),
		.right_ticks (right_ticks),
		.left_ticks  (left_ticks),
		.cmd         (cmd),
		.stat        (stat),
		.pos_x       (pos_x),
		.pos_y       (pos_y),
		.heading     (heading)
	);

endmodule
